// File: hw/rtl/homogeneous_vertex_transform_macros.svh
// ============================================================================
// Assertion macros for the homogeneous vertex transform
// Shared concurrent assertion forms. Each expects clk and rst_n in scope.
// ============================================================================
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HVT_ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion %m failed");

// Next-cycle implication, disabled while reset is asserted.
`define HVT_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion %m failed");

`endif

// File: hw/rtl/hvt_pkg.sv
// ============================================================================
// hvt_pkg
// Constants, register indexes, the pipeline control type and width helpers
// for the homogeneous vertex transform.
// ============================================================================
package hvt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int NUM_REGS    = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int HALF_W      = 32;
    localparam int NUM_LANES   = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    // Load enables of the three lane stages.
    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
    } hvt_adv_t;

    // Matrix entries use at most one register half.
    function automatic int entry_bits(input int cw);
        return (cw < HALF_W) ? cw : HALF_W;
    endfunction

    // Width that holds the exact sum of three products and the aligned row-3 term.
    function automatic int sum_width(input int cw, input int fb);
        int prod_w;
        int trans_w;
        prod_w  = cw + entry_bits(cw);
        trans_w = entry_bits(cw) + fb;
        return ((prod_w > trans_w) ? prod_w : trans_w) + 2;
    endfunction

    // Identity matrix: the diagonal entries are 1.0.
    function automatic logic [CFG_DATA_W-1:0] cfg_reset(input logic [CFG_INDEX_W-1:0] idx,
                                                         input int fb);
        logic [CFG_DATA_W-1:0] one;
        one = CFG_DATA_W'(1) << fb;
        case (idx)
            REG_ROW0_COLS01: return one;
            REG_ROW1_COLS01: return one << HALF_W;
            REG_ROW2_COLS23: return one;
            REG_ROW3_COLS23: return one << HALF_W;
            default:         return '0;
        endcase
    endfunction

endpackage

// File: hw/rtl/hvt_lane.sv
// ============================================================================
// hvt_lane
// One output column: three products, a pair of partial sums, then the total.
// ============================================================================
module hvt_lane #(
    parameter int COORD_WIDTH = hvt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                                                    clk,
    input  hvt_pkg::hvt_adv_t                                       adv,
    input  logic signed [COORD_WIDTH-1:0]                           vx,
    input  logic signed [COORD_WIDTH-1:0]                           vy,
    input  logic signed [COORD_WIDTH-1:0]                           vz,
    input  logic signed [hvt_pkg::entry_bits(COORD_WIDTH)-1:0]      m0,
    input  logic signed [hvt_pkg::entry_bits(COORD_WIDTH)-1:0]      m1,
    input  logic signed [hvt_pkg::entry_bits(COORD_WIDTH)-1:0]      m2,
    input  logic signed [hvt_pkg::entry_bits(COORD_WIDTH)-1:0]      mt,
    output logic signed [hvt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0] sum
);
    import hvt_pkg::*;

    localparam int EB     = entry_bits(COORD_WIDTH);
    localparam int PROD_W = COORD_WIDTH + EB;
    localparam int SUM_W  = sum_width(COORD_WIDTH, FRAC_BITS);

    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [PROD_W-1:0] p0_next, p1_next, p2_next;
    logic signed [EB-1:0]     mt_reg;
    logic signed [SUM_W-1:0]  a_reg, b_reg, sum_reg;
    logic signed [SUM_W-1:0]  a_next, b_next, sum_next;

    assign p0_next  = vx * m0;
    assign p1_next  = vy * m1;
    assign p2_next  = vz * m2;
    assign a_next   = SUM_W'(p0_reg) + SUM_W'(p1_reg);
    // The row-3 entry is lined up with the product fraction bits.
    assign b_next   = SUM_W'(p2_reg) + (SUM_W'(mt_reg) <<< FRAC_BITS);
    assign sum_next = a_reg + b_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s1_en)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            mt_reg <= mt;
        end
        if (adv.s2_en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (adv.s3_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// File: hw/rtl/hvt_merge.sv
// ============================================================================
// hvt_merge
// Shifts and saturates the four column sums and holds the output beat.
// ============================================================================
module hvt_merge #(
    parameter int COORD_WIDTH = hvt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                                                              clk,
    input  logic                                                              rst_n,
    input  logic [hvt_pkg::NUM_LANES-1:0][hvt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0]
                                                                              lane_sum,
    input  logic                                                              s3_valid,
    input  logic                                                              out_stall,
    output logic                                                              take,
    output logic                                                              out_valid,
    output logic [hvt_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0]                    result
);
    import hvt_pkg::*;

    localparam int SUM_W = sum_width(COORD_WIDTH, FRAC_BITS);
    localparam int TOP_W = SUM_W - (FRAC_BITS + COORD_WIDTH - 1);

    logic                                   out_valid_reg, out_valid_next;
    logic [NUM_LANES-1:0][COORD_WIDTH-1:0]  result_reg, result_next;

    // The floor shift is just dropping the fraction bits; the value fits when
    // every bit above the kept field matches its sign bit.
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_sat
        logic [TOP_W-1:0] top_bits;
        logic             in_range;
        assign top_bits = lane_sum[l][SUM_W-1 -: TOP_W];
        assign in_range = (&top_bits) | ~(|top_bits);
        assign result_next[l] = in_range ? lane_sum[l][FRAC_BITS +: COORD_WIDTH] :
                                lane_sum[l][SUM_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} :
                                                       {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end

    assign take           = !out_valid_reg || !out_stall;
    assign out_valid_next = take ? s3_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// File: hw/rtl/homogeneous_vertex_transform.sv
// ============================================================================
// homogeneous_vertex_transform
// Row-vector (x, y, z, 1) times a 4x4 fixed-point matrix, saturated output.
// ============================================================================
// The block accepts one vertex per clock while in_stall is low and delivers
// one transformed beat per vertex after stages s1-s3 and the result register.
// Four column lanes, each with three multipliers and a two-level adder, run
// side by side; the result register drains in the same cycle it is taken, so
// a full pipeline holds four vertices before input stall rises. The matrix
// resets to identity and should only be written while no vertex is in flight.
`include "homogeneous_vertex_transform_macros.svh"

module homogeneous_vertex_transform #(
    parameter int COORD_WIDTH = hvt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hvt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hvt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COORD_WIDTH-1:0]      in_x,
    input  logic signed [COORD_WIDTH-1:0]      in_y,
    input  logic signed [COORD_WIDTH-1:0]      in_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [COORD_WIDTH-1:0]      out_x,
    output logic signed [COORD_WIDTH-1:0]      out_y,
    output logic signed [COORD_WIDTH-1:0]      out_z,
    output logic signed [COORD_WIDTH-1:0]      out_w
);
    import hvt_pkg::*;

    localparam int EB    = entry_bits(COORD_WIDTH);
    localparam int SUM_W = sum_width(COORD_WIDTH, FRAC_BITS);

    logic [CFG_DATA_W-1:0]                  mat_reg [NUM_REGS];
    logic                                   v1_reg, v2_reg, v3_reg;
    logic                                   v1_next, v2_next, v3_next;
    hvt_adv_t                               adv;
    logic                                   take;
    logic [NUM_LANES-1:0][SUM_W-1:0]        lane_sum;
    logic [NUM_LANES-1:0][COORD_WIDTH-1:0]  result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                mat_reg[i] <= cfg_reset(CFG_INDEX_W'(i), FRAC_BITS);
            end
        end
        else if (cfg_we)
        begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    // A stage loads when it is empty or its contents move on this cycle.
    assign adv.s3_en = !v3_reg || take;
    assign adv.s2_en = !v2_reg || adv.s3_en;
    assign adv.s1_en = !v1_reg || adv.s2_en;
    assign in_stall  = !adv.s1_en;

    assign v1_next = adv.s1_en ? in_valid : v1_reg;
    assign v2_next = adv.s2_en ? v1_reg   : v2_reg;
    assign v3_next = adv.s3_en ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Column j of row r sits in register 2r + j/2, half j%2.
    for (genvar j = 0; j < NUM_LANES; j++)
    begin : g_lane
        localparam int RSEL = j / 2;
        localparam int HOFS = (j % 2) * HALF_W;

        hvt_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_lane (
            .clk (clk),
            .adv (adv),
            .vx  (in_x),
            .vy  (in_y),
            .vz  (in_z),
            .m0  ($signed(mat_reg[0 + RSEL][HOFS +: EB])),
            .m1  ($signed(mat_reg[2 + RSEL][HOFS +: EB])),
            .m2  ($signed(mat_reg[4 + RSEL][HOFS +: EB])),
            .mt  ($signed(mat_reg[6 + RSEL][HOFS +: EB])),
            .sum (lane_sum[j])
        );
    end

    hvt_merge #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_sum  (lane_sum),
        .s3_valid  (v3_reg),
        .out_stall (out_stall),
        .take      (take),
        .out_valid (out_valid),
        .result    (result)
    );

    assign out_x = result[0];
    assign out_y = result[1];
    assign out_z = result[2];
    assign out_w = result[3];

    `HVT_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, v1_reg)
    `HVT_ASSERT_IMPL(a_stall_only_when_full, !(v1_reg && v2_reg && v3_reg && out_valid), !in_stall)
    `HVT_ASSERT_NEXT(a_s3_reaches_output, v3_reg && !out_stall, out_valid)
    `HVT_ASSERT_NEXT(a_output_drains, out_valid && !out_stall && !v3_reg, !out_valid)

endmodule
